// ===== hdl/ts_outer_coder_ed_rs_interleave_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Outer coder assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TS_OUTER_CODER_ED_RS_INTERLEAVE_UNIT_DEFINES_SVH
`define TS_OUTER_CODER_ED_RS_INTERLEAVE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define TSOC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define TSOC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define TSOC_ASSERT_IMP(label, clk, rst, ante, cons)
`define TSOC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/tsoc_pkg.sv =====
// ----------------------------------------------------------------------------
// Outer coder package
// Sizes, seeds and GF(256) helpers shared by the front and back parts.
// ----------------------------------------------------------------------------
package tsoc_pkg;
   localparam int Branches     = 12;
   localparam int CellDepth    = 17;
   localparam int PacketBytes  = 188;
   localparam int GroupPackets = 8;
   localparam int ParityBytes  = 16;
   localparam int StoreSize    = CellDepth * Branches * (Branches - 1) / 2;
   localparam int AddrW        = $clog2(StoreSize);
   localparam int BrW          = $clog2(Branches);
   localparam int PosW         = $clog2(CellDepth * (Branches - 1) + 1);
   localparam logic [14:0] LfsrSeed = 15'h00A9;
   localparam logic [7:0]  SyncInvert = 8'hFF;

   typedef logic [7:0] gen_type [ParityBytes];
   localparam gen_type GenCoef = '{8'd59, 8'd13, 8'd104, 8'd189, 8'd68, 8'd209,
      8'd30, 8'd8, 8'd163, 8'd65, 8'd41, 8'd229, 8'd98, 8'd50, 8'd36, 8'd59};

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } qent_type;

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] x;
      logic [7:0] r;
      x = a;
      r = '0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) r = r ^ x;
         x = x[7] ? ((x << 1) ^ 8'h1D) : (x << 1);
      end
      return r;
   endfunction

   function automatic logic [AddrW-1:0] branch_base(input logic [BrW-1:0] j);
      int unsigned t;
      t = CellDepth * j * (j - 1) / 2;
      return AddrW'(t);
   endfunction

   function automatic logic [PosW-1:0] branch_len(input logic [BrW-1:0] j);
      return PosW'(CellDepth * int'(j));
   endfunction
endpackage

// ===== hdl/tsoc_front.sv =====
// ----------------------------------------------------------------------------
// Outer coder front part
// Scrambles input bytes, runs the RS parity register, queues coded bytes.
// ----------------------------------------------------------------------------
module tsoc_front import tsoc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_stream_byte,
   output logic       q_wr,
   output qent_type   q_wdata,
   input  logic       q_full
);
   logic [14:0] lfsr_ff, lfsr_in;
   logic [2:0]  pkt_ff;
   logic [7:0]  byte_ff;
   logic [7:0]  par_ff [ParityBytes];
   logic [4:0]  pcnt_ff;
   logic        pbusy_ff;
   logic [7:0]  prbs, d, fb;
   logic        take;

   always_comb begin
      logic [14:0] s;
      logic        f;
      s = lfsr_ff;
      prbs = '0;
      for (int k = 0; k < 8; k++) begin
         f = s[13] ^ s[14];
         s = {s[13:0], f};
         prbs = {prbs[6:0], f};
      end
      lfsr_in = s;
   end

   assign req_stall = pbusy_ff || q_full;
   assign take = req_valid && !req_stall;

   always_comb begin
      if (byte_ff == 8'd0) d = (pkt_ff == 3'd0) ? (req_stream_byte ^ SyncInvert) : req_stream_byte;
      else d = req_stream_byte ^ prbs;
      fb = d ^ par_ff[0];
   end

   always_comb begin
      q_wr = take || (pbusy_ff && !q_full);
      if (pbusy_ff) begin
         q_wdata.data = par_ff[pcnt_ff[3:0]];
         q_wdata.last = (pcnt_ff == 5'(ParityBytes - 1));
      end else begin
         q_wdata.data = d;
         q_wdata.last = (byte_ff != 8'(PacketBytes - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff  <= LfsrSeed;
         pkt_ff   <= '0;
         byte_ff  <= '0;
         pcnt_ff  <= '0;
         pbusy_ff <= 1'b0;
         for (int i = 0; i < ParityBytes; i++) par_ff[i] <= '0;
      end else if (pbusy_ff) begin
         if (!q_full) begin
            if (pcnt_ff == 5'(ParityBytes - 1)) begin
               pbusy_ff <= 1'b0;
               for (int i = 0; i < ParityBytes; i++) par_ff[i] <= '0;
            end
            pcnt_ff <= pcnt_ff + 5'd1;
         end
      end else if (take) begin
         if (byte_ff == 8'd0 && pkt_ff == 3'd0) lfsr_ff <= LfsrSeed;
         else lfsr_ff <= lfsr_in;
         for (int i = 0; i < ParityBytes - 1; i++)
            par_ff[i] <= par_ff[i+1] ^ gf_mul(fb, GenCoef[i]);
         par_ff[ParityBytes-1] <= gf_mul(fb, GenCoef[ParityBytes-1]);
         if (byte_ff == 8'(PacketBytes - 1)) begin
            byte_ff  <= '0;
            pkt_ff   <= 3'(({29'd0, pkt_ff} + 1) % GroupPackets);
            pbusy_ff <= 1'b1;
            pcnt_ff  <= '0;
         end else begin
            byte_ff <= byte_ff + 8'd1;
         end
      end
   end
endmodule

// ===== hdl/tsoc_queue.sv =====
// ----------------------------------------------------------------------------
// Outer coder queue
// Four-entry FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module tsoc_queue import tsoc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     wr,
   input  qent_type wdata,
   output logic     full,
   input  logic     rd,
   output logic     nempty,
   output qent_type rdata
);
   qent_type   mem_ff [4];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff;

   assign full   = (cnt_ff == 3'd4);
   assign nempty = (cnt_ff != 3'd0);
   assign rdata  = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (wr) mem_ff[wp_ff] <= wdata;
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= wp_ff + 2'd1;
         if (rd) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + {2'd0, wr} - {2'd0, rd};
      end
   end
endmodule

// ===== hdl/tsoc_back.sv =====
// ----------------------------------------------------------------------------
// Outer coder back part
// Forney interleaver: reads the delay memory, writes the new byte, outputs.
// ----------------------------------------------------------------------------
module tsoc_back import tsoc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_nempty,
   input  qent_type   q_rdata,
   output logic       q_rd,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_coded_byte,
   output logic       rsp_run_last,
   output logic       busy_clear
);
   logic [7:0]       mem [StoreSize];
   logic [AddrW-1:0] clr_ff;
   logic             clr_ff_on;
   logic [BrW-1:0]   br_ff;
   logic [PosW-1:0]  pos_ff [Branches];
   logic             s1_ff, s1_direct_ff, s1_last_ff;
   logic [7:0]       s1_data_ff, rd_ff;
   logic             out_v_ff, out_last_ff;
   logic [7:0]       out_d_ff;
   logic             adv, s1_go;
   logic [AddrW-1:0] addr;
   logic [PosW-1:0]  npos;

   assign busy_clear = clr_ff_on;
   assign s1_go = s1_ff && (!out_v_ff || !rsp_stall);
   assign adv   = q_nempty && !clr_ff_on && (!s1_ff || s1_go);
   assign q_rd  = adv;
   assign addr  = branch_base(br_ff) + AddrW'(pos_ff[br_ff]);
   assign npos  = (pos_ff[br_ff] + 1'b1 >= branch_len(br_ff)) ? '0 : pos_ff[br_ff] + 1'b1;

   assign rsp_valid      = out_v_ff;
   assign rsp_coded_byte = out_d_ff;
   assign rsp_run_last   = out_last_ff;

   always_ff @(posedge clock) begin
      if (clr_ff_on) mem[clr_ff] <= '0;
      else if (adv && br_ff != '0) begin
         mem[addr] <= q_rdata.data;
      end
      if (adv) rd_ff <= mem[addr];
      if (adv) begin
         s1_data_ff   <= q_rdata.data;
         s1_direct_ff <= (br_ff == '0);
         s1_last_ff   <= q_rdata.last;
      end
      if (s1_go) begin
         out_d_ff    <= s1_direct_ff ? s1_data_ff : rd_ff;
         out_last_ff <= s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff    <= '0;
         clr_ff_on <= 1'b1;
         br_ff     <= '0;
         s1_ff     <= 1'b0;
         out_v_ff  <= 1'b0;
         for (int i = 0; i < Branches; i++) pos_ff[i] <= '0;
      end else begin
         if (clr_ff_on) begin
            if (clr_ff == AddrW'(StoreSize - 1)) clr_ff_on <= 1'b0;
            clr_ff <= clr_ff + 1'b1;
         end
         if (adv) begin
            if (br_ff != '0) pos_ff[br_ff] <= npos;
            br_ff <= (br_ff == BrW'(Branches - 1)) ? '0 : br_ff + 1'b1;
         end
         if (adv) s1_ff <= 1'b1;
         else if (s1_go) s1_ff <= 1'b0;
         if (s1_go) out_v_ff <= 1'b1;
         else if (!rsp_stall) out_v_ff <= 1'b0;
      end
   end
endmodule

// ===== hdl/ts_outer_coder_ed_rs_interleave_unit.sv =====
// ----------------------------------------------------------------------------
// Outer coder top level
// Energy dispersal, RS(204,188) parity and Forney interleaving of a TS.
// ----------------------------------------------------------------------------
// channel | ports                                  | direction
// req     | req_valid req_stall req_stream_byte    | in
// rsp     | rsp_valid rsp_stall rsp_coded_byte     | out
//         | rsp_run_last                           |
// One input byte a cycle while the queue has room; after the last byte of a packet
// the front drains its 16 parity bytes, during which req_stall is high (front parity drain).
// After reset the 1122-byte delay memory is cleared; input queues up
// to four bytes meanwhile, no result leaves.
// Results pass the queue, s1 and output registers; rsp_stall holds the output register.
// ----------------------------------------------------------------------------
`include "ts_outer_coder_ed_rs_interleave_unit_defines.svh"
module ts_outer_coder_ed_rs_interleave_unit import tsoc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_stream_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_coded_byte,
   output logic       rsp_run_last
);
   logic     q_wr, q_full, q_rd, q_nempty, clearing;
   qent_type q_wdata, q_rdata;

   tsoc_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_stream_byte,
      .q_wr, .q_wdata, .q_full
   );

   tsoc_queue u_queue (
      .clock, .reset, .wr(q_wr), .wdata(q_wdata), .full(q_full),
      .rd(q_rd), .nempty(q_nempty), .rdata(q_rdata)
   );

   tsoc_back u_back (
      .clock, .reset, .q_nempty, .q_rdata, .q_rd, .rsp_valid, .rsp_stall,
      .rsp_coded_byte, .rsp_run_last, .busy_clear(clearing)
   );

   `TSOC_ASSERT_IMP(a_no_wr_full, clock, reset, q_full, !(q_wr && !q_rd))
   `TSOC_ASSERT_IMP(a_no_rd_empty, clock, reset, q_rd, q_nempty)
   `TSOC_ASSERT_IMP(a_clear_quiet, clock, reset, clearing, !q_rd)
   `TSOC_ASSERT_NXT(a_out_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_coded_byte))
endmodule

// ===== tb/sv/ts_outer_coder_ed_rs_interleave_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Outer coder testbench
// Feeds packet-aligned transport stream bytes with random gaps and random
// result stalls, predicts scrambled, RS-coded, interleaved bytes in-line and
// compares every result transfer against the oldest predicted byte.
// ----------------------------------------------------------------------------
module ts_outer_coder_ed_rs_interleave_unit_tb import tsoc_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WatchLimit = 20000;

   typedef struct {
      logic [7:0] coded;
      logic       last;
   } coded_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_stream_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_coded_byte;
   logic       rsp_run_last;

   logic [7:0] stream_q[$];
   coded_type  coded_q[$];
   bit         stim_done;
   bit         failed;
   int         req_wait;
   int         rsp_wait;
   int         idle_cycles;

   logic [14:0] scr_state;
   int          pkt_index;
   int          byte_index;
   logic [7:0]  parity[ParityBytes];
   int          branch;
   logic [7:0]  fifo_mem[StoreSize];
   int          fifo_pos[Branches];

   ts_outer_coder_ed_rs_interleave_unit u_top (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
      logic [8:0] x;
      logic [7:0] r;
      x = {1'b0, a};
      r = '0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) r ^= x[7:0];
         x = x << 1;
         if (x[8]) x ^= 9'h11D;
      end
      return r;
   endfunction

   function automatic logic [7:0] prbs_next();
      logic [7:0] o;
      logic       fb;
      o = '0;
      for (int k = 0; k < 8; k++) begin
         fb = scr_state[13] ^ scr_state[14];
         scr_state = {scr_state[13:0], fb};
         o = {o[6:0], fb};
      end
      return o;
   endfunction

   function automatic void push_interleaved(logic [7:0] b, logic last);
      int len;
      int idx;
      coded_type c;
      c.coded = b;
      c.last = last;
      len = branch * CellDepth;
      if (len != 0) begin
         idx = CellDepth * branch * (branch - 1) / 2 + fifo_pos[branch];
         c.coded = fifo_mem[idx];
         fifo_mem[idx] = b;
         fifo_pos[branch] = (fifo_pos[branch] + 1) % len;
      end
      branch = (branch + 1) % Branches;
      coded_q.push_back(c);
   endfunction

   function automatic void predict_coded(logic [7:0] b);
      logic [7:0] d;
      logic [7:0] fb;
      logic [7:0] dummy;
      bit         pkt_end;
      if (byte_index == 0) begin
         if (pkt_index == 0) begin
            scr_state = LfsrSeed;
            d = b ^ SyncInvert;
         end else begin
            dummy = prbs_next();
            d = b;
         end
      end else begin
         d = b ^ prbs_next();
      end
      fb = d ^ parity[0];
      for (int i = 0; i < ParityBytes - 1; i++)
         parity[i] = parity[i + 1] ^ gmul(fb, GenCoef[i]);
      parity[ParityBytes - 1] = gmul(fb, GenCoef[ParityBytes - 1]);
      pkt_end = (byte_index == PacketBytes - 1);
      push_interleaved(d, !pkt_end);
      if (pkt_end) begin
         for (int i = 0; i < ParityBytes; i++)
            push_interleaved(parity[i], i == ParityBytes - 1);
         for (int i = 0; i < ParityBytes; i++) parity[i] = '0;
         byte_index = 0;
         pkt_index = (pkt_index + 1) % GroupPackets;
      end else begin
         byte_index++;
      end
   endfunction

   initial begin
      scr_state = LfsrSeed;
      pkt_index = 0;
      byte_index = 0;
      branch = 0;
      for (int i = 0; i < ParityBytes; i++) parity[i] = '0;
      for (int i = 0; i < StoreSize; i++) fifo_mem[i] = '0;
      for (int i = 0; i < Branches; i++) fifo_pos[i] = 0;
      // directed extremes at the head of the first packet, then random bytes
      stream_q.push_back(8'h47);
      stream_q.push_back(8'h00);
      stream_q.push_back(8'hFF);
      stream_q.push_back(8'h55);
      stream_q.push_back(8'hAA);
      for (int i = 0; i < 8; i++) stream_q.push_back(8'h01 << i);
      for (int i = 13; i < 120; i++) stream_q.push_back(8'($urandom_range(0, 255)));
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_stream_byte <= '0;
         req_wait <= $urandom_range(0, 18);
         stim_done <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_coded(req_stream_byte);
            void'(stream_q.pop_front());
         end
         if (req_valid && req_stall) begin
            // hold the stalled transfer
         end else if (req_wait > 0 && !(req_valid && !req_stall && stream_q.size() == 0)) begin
            req_valid <= 1'b0;
            req_wait <= req_wait - 1;
         end else if (stream_q.size() > 0) begin
            req_valid <= 1'b1;
            req_stream_byte <= stream_q[0];
            req_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
         end else begin
            req_valid <= 1'b0;
            stim_done <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      coded_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (coded_q.size() == 0) begin
               $error("unexpected transfer coded_byte %h", rsp_coded_byte);
               failed = 1'b1;
            end else begin
               e = coded_q.pop_front();
               if (rsp_coded_byte !== e.coded) begin
                  $error("coded_byte expected %h actual %h", e.coded, rsp_coded_byte);
                  failed = 1'b1;
               end
               if (rsp_run_last !== e.last) begin
                  $error("run_last expected %b actual %b", e.last, rsp_run_last);
                  failed = 1'b1;
               end
            end
            rsp_wait <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
            rsp_stall <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_stall <= 1'b1;
            rsp_wait <= rsp_wait - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      failed = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_stream_byte = '0;
      rsp_stall = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      idle_cycles = 0;
      while (!(stim_done && coded_q.size() == 0) && idle_cycles < WatchLimit) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
      end
      if (idle_cycles >= WatchLimit) begin
         $display("[ts_outer_coder_ed_rs_interleave_unit] ERROR");
      end else begin
         repeat (50) @(posedge clock);
         if (!failed) $display("[ts_outer_coder_ed_rs_interleave_unit] OK");
         else $display("[ts_outer_coder_ed_rs_interleave_unit] ERROR");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/tsoc_pkg.sv
hdl/tsoc_front.sv
hdl/tsoc_queue.sv
hdl/tsoc_back.sv
hdl/ts_outer_coder_ed_rs_interleave_unit.sv
tb/sv/ts_outer_coder_ed_rs_interleave_unit_tb.sv
